### src/ray_sphere_intersect_defines.svh
// ----------------------------------------------------------------------------
// ray sphere intersect assertion macros
// shared property forms for the ray sphere datapath checks
// ----------------------------------------------------------------------------
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define RSI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// fixed widths, register codes and cell sizes for the ray sphere datapath
// ----------------------------------------------------------------------------
package rsi_pkg;

   localparam int IN_W       = 32;             // one coordinate field
   localparam int REQ_W      = 6 * IN_W;       // origin xyz, direction xyz
   localparam int RAD_W      = 31;             // radius field
   localparam int DIST_W     = 31;             // hit distance field
   localparam int RSP_W      = 32;             // hit + distance
   localparam int DIG_W      = 16;             // multiplier digit per cell
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CENTER_X = 4'd0,
      REG_CENTER_Y = 4'd1,
      REG_CENTER_Z = 4'd2,
      REG_RADIUS   = 4'd3
   } csr_reg_type;

endpackage

### src/rsi_mul.sv
// ----------------------------------------------------------------------------
// rsi_mul
// digit-serial multiplier row, one DIG_W-bit digit of b per cell
// ----------------------------------------------------------------------------
module rsi_mul import rsi_pkg::*; #(
   parameter int AW = 33,
   parameter int BW = 33,
   parameter int PW = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   input  logic [PW-1:0]    pay_in,
   output logic [AW+BW-1:0] prod,
   output logic [PW-1:0]    pay_out
);

   localparam int NC   = (BW + DIG_W - 1) / DIG_W;
   localparam int XW   = NC * DIG_W;
   localparam int PPW  = AW + DIG_W;
   localparam int ACCW = AW + BW;

   logic [AW-1:0]   a_ff   [NC];
   logic [XW-1:0]   b_ff   [NC];
   logic [ACCW-1:0] acc_ff [NC];
   logic [PW-1:0]   pay_ff [NC];

   for (genvar i = 0; i < NC; i++) begin : g_cell
      logic [AW-1:0]   a_in;
      logic [XW-1:0]   b_in;
      logic [ACCW-1:0] acc_prev;
      logic [ACCW-1:0] acc_in;
      logic [PW-1:0]   pay_c;
      logic [PPW-1:0]  pp;

      if (i == 0) begin : g_first
         assign a_in     = a;
         assign b_in     = XW'(b);
         assign acc_prev = '0;
         assign pay_c    = pay_in;
      end else begin : g_next
         assign a_in     = a_ff[i-1];
         assign b_in     = b_ff[i-1];
         assign acc_prev = acc_ff[i-1];
         assign pay_c    = pay_ff[i-1];
      end

      // partial product of this cell's digit
      assign pp     = PPW'(a_in) * PPW'(b_in[i*DIG_W +: DIG_W]);
      assign acc_in = acc_prev + (ACCW'(pp) << (i * DIG_W));

      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[i]   <= a_in;
            b_ff[i]   <= b_in;
            acc_ff[i] <= acc_in;
            pay_ff[i] <= pay_c;
         end
      end
   end

   assign prod    = acc_ff[NC-1];
   assign pay_out = pay_ff[NC-1];

endmodule

### src/rsi_sqrt.sv
// ----------------------------------------------------------------------------
// rsi_sqrt
// integer square root row, one root bit per cell, most significant first
// ----------------------------------------------------------------------------
module rsi_sqrt import rsi_pkg::*; #(
   parameter int DW = 131,
   parameter int PW = 1
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DW-1:0]         rad,
   input  logic [PW-1:0]         pay_in,
   output logic [(DW+1)/2-1:0]   root,
   output logic [PW-1:0]         pay_out
);

   localparam int SW  = (DW + 1) / 2;
   localparam int CDW = DW + 1;

   logic [DW-1:0] rem_ff  [SW];
   logic [SW-1:0] root_ff [SW];
   logic [PW-1:0] pay_ff  [SW];

   for (genvar j = 0; j < SW; j++) begin : g_cell
      localparam int K = SW - 1 - j;
      logic [DW-1:0]  rem_prev;
      logic [SW-1:0]  root_prev;
      logic [PW-1:0]  pay_c;
      logic [CDW-1:0] cand;
      logic           take;
      logic [DW-1:0]  rem_in;
      logic [SW-1:0]  root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = rad;
         assign root_prev = '0;
         assign pay_c     = pay_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign pay_c     = pay_ff[j-1];
      end

      // (2*root + 2^k) * 2^k, root holds only bits above k
      assign cand    = (CDW'(root_prev) << (K + 1)) | (CDW'(1) << (2 * K));
      assign take    = {1'b0, rem_prev} >= cand;
      assign rem_in  = take ? rem_prev - cand[DW-1:0] : rem_prev;
      assign root_in = take ? (root_prev | (SW'(1) << K)) : root_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            pay_ff[j]  <= pay_c;
         end
      end
   end

   assign root    = root_ff[SW-1];
   assign pay_out = pay_ff[SW-1];

endmodule

### src/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div
// restoring divider row, one quotient bit per cell, saturates at all ones
// ----------------------------------------------------------------------------
module rsi_div import rsi_pkg::*; #(
   parameter int NW = 67,
   parameter int AW = 64,
   parameter int FB = 16,
   parameter int PW = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NW-1:0]     num,
   input  logic [AW-1:0]     den,
   input  logic [PW-1:0]     pay_in,
   output logic [DIST_W-1:0] quo,
   output logic [PW-1:0]     pay_out
);

   localparam int QB = DIST_W;
   localparam int RW = (NW + FB > AW + QB) ? NW + FB : AW + QB;

   logic [RW-1:0] rem_ff [QB];
   logic [AW-1:0] den_ff [QB];
   logic [QB-1:0] q_ff   [QB];
   logic [PW-1:0] pay_ff [QB];

   for (genvar j = 0; j < QB; j++) begin : g_cell
      localparam int K = QB - 1 - j;
      logic [RW-1:0] rem_prev;
      logic [AW-1:0] den_prev;
      logic [QB-1:0] q_prev;
      logic [PW-1:0] pay_c;
      logic [RW-1:0] cand;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QB-1:0] q_in;

      if (j == 0) begin : g_first
         assign rem_prev = RW'(num) << FB;
         assign den_prev = den;
         assign q_prev   = '0;
         assign pay_c    = pay_in;
      end else begin : g_next
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign q_prev   = q_ff[j-1];
         assign pay_c    = pay_ff[j-1];
      end

      assign cand   = RW'(den_prev) << K;
      assign take   = rem_prev >= cand;
      assign rem_in = take ? rem_prev - cand : rem_prev;
      assign q_in   = take ? (q_prev | (QB'(1) << K)) : q_prev;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in;
            den_ff[j] <= den_prev;
            q_ff[j]   <= q_in;
            pay_ff[j] <= pay_c;
         end
      end
   end

   assign quo     = q_ff[QB-1];
   assign pay_out = pay_ff[QB-1];

endmodule

### src/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray sphere intersect
// quadratic ray / sphere hit test over rows of multiplier, root and divider
// cells, while no untaken result freezes the stages, one ray per cycle
// ----------------------------------------------------------------------------
//  channel   ports                         moves
//  req       req_tvalid/tready/tdata       one ray request (origin, direction)
//  rsp       rsp_tvalid/tready/tdata       one result request (hit, distance)
//  csr       csr_valid/ready/index/data    sphere register write
//
//  one ray enters per cycle unless a result not taken freezes the stages;
//  the per-axis multiplier rows have NC1 = ceil((COORD_WIDTH+1)/16) cells,
//  the B*B and A*K rows NC2 = ceil((2*COORD_WIDTH+1)/16) and the root row SW;
//  the square root row (one bit per cell) and the divider rows set the depth
//  reset clears the valid line and the sphere registers, nothing else
//  a result not taken freezes every stage; the last stage is the output reg
// ----------------------------------------------------------------------------
`include "ray_sphere_intersect_defines.svh"

module ray_sphere_intersect import rsi_pkg::*; #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, 32 bits each
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit [0], hit_distance [31:1]
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int CW   = COORD_WIDTH;
   localparam int XW   = (CW > IN_W) ? CW : IN_W;
   localparam int VW   = CW + 1;                       // o - c and magnitudes
   localparam int AW   = 2 * CW;                       // d.d
   localparam int BW   = 2 * CW + 1;                   // |v.d|
   localparam int KW   = (2 * CW + 2 > 2 * RAD_W) ? 2 * CW + 2 : 2 * RAD_W;
   localparam int R2W  = 2 * RAD_W;
   localparam int NC1  = (VW + DIG_W - 1) / DIG_W;
   localparam int NC2  = (BW + DIG_W - 1) / DIG_W;
   localparam int DW   = ((2 * BW > KW + BW) ? 2 * BW : KW + BW) + 1;
   localparam int SW   = (DW + 1) / 2;
   localparam int NW   = ((BW > SW) ? BW : SW) + 1;
   localparam int LAT  = 6 + NC1 + NC2 + SW + DIST_W;
   localparam int EPS  = (2 ** FRAC_BITS + 9999) / 10000;
   localparam int P2W  = AW + BW + 3;
   localparam int PSW  = AW + BW + 2;

   // low COORD_WIDTH bits of a field, sign extended
   function automatic logic signed [VW-1:0] coord(input logic [IN_W-1:0] f);
      logic [XW-1:0] e;
      e = XW'(f);
      return VW'(signed'(e[CW-1:0]));
   endfunction

   // ---------------- sphere registers ----------------
   logic [2:0][IN_W-1:0] center_ff;
   logic [RAD_W-1:0]     radius_ff;
   logic [R2W-1:0]       r2_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         radius_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_reg_type'(csr_index))
            REG_CENTER_X: center_ff[0] <= csr_data;
            REG_CENTER_Y: center_ff[1] <= csr_data;
            REG_CENTER_Z: center_ff[2] <= csr_data;
            REG_RADIUS:   radius_ff    <= csr_data[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // r squared follows the radius in the next cycle, long before any ray needs it
   always_ff @(posedge clock) begin
      if (reset) begin
         r2_ff <= '0;
      end else begin
         r2_ff <= R2W'(radius_ff) * R2W'(radius_ff);
      end
   end

   // ---------------- valid line and flow control ----------------
   logic [LAT-1:0] vld_ff;
   logic           adv;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ---------------- stage 1: v = o - c, magnitudes and signs ----------------
   logic signed [VW-1:0] vdiff [3];
   logic signed [VW-1:0] dval  [3];
   logic [2:0][VW-1:0]   vm_in, dm_in;
   logic [2:0]           sn_in;
   logic [2:0][VW-1:0]   vm_ff, dm_ff;
   logic [2:0]           sn_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vdiff[i] = coord(req_tdata[i*IN_W +: IN_W]) - coord(center_ff[i]);
         dval[i]  = coord(req_tdata[(3+i)*IN_W +: IN_W]);
         vm_in[i] = vdiff[i][VW-1] ? VW'(-vdiff[i]) : VW'(vdiff[i]);
         dm_in[i] = dval[i][VW-1] ? VW'(-dval[i]) : VW'(dval[i]);
         // sign of the v*d term
         sn_in[i] = vdiff[i][VW-1] ^ dval[i][VW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vm_ff <= vm_in;
         dm_ff <= dm_in;
         sn_ff <= sn_in;
      end
   end

   // ---------------- per-axis products ----------------
   logic [2:0][2*VW-1:0] dd_p, vd_p, vv_p;
   logic [2:0]           sn_m1;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      rsi_mul #(.AW(VW), .BW(VW), .PW(1)) u_dd (
         .clock(clock), .en(adv), .a(dm_ff[i]), .b(dm_ff[i]),
         .pay_in(1'b0), .prod(dd_p[i]), .pay_out()
      );
      rsi_mul #(.AW(VW), .BW(VW), .PW(1)) u_vd (
         .clock(clock), .en(adv), .a(vm_ff[i]), .b(dm_ff[i]),
         .pay_in(sn_ff[i]), .prod(vd_p[i]), .pay_out(sn_m1[i])
      );
      rsi_mul #(.AW(VW), .BW(VW), .PW(1)) u_vv (
         .clock(clock), .en(adv), .a(vm_ff[i]), .b(vm_ff[i]),
         .pay_in(1'b0), .prod(vv_p[i]), .pay_out()
      );
   end

   // ---------------- stage 2: dot product sums ----------------
   logic [AW-1:0] a_in2, a2_ff;
   logic [BW-1:0] pos_in, neg_in, pos_ff, neg_ff;
   logic [KW-1:0] vv_in, vv_ff;

   always_comb begin
      a_in2  = '0;
      pos_in = '0;
      neg_in = '0;
      vv_in  = '0;
      for (int i = 0; i < 3; i++) begin
         a_in2 = a_in2 + AW'(dd_p[i]);
         if (sn_m1[i]) neg_in = neg_in + BW'(vd_p[i]);
         else          pos_in = pos_in + BW'(vd_p[i]);
         vv_in = vv_in + KW'(vv_p[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a2_ff  <= a_in2;
         pos_ff <= pos_in;
         neg_ff <= neg_in;
         vv_ff  <= vv_in;
      end
   end

   // ---------------- stage 3: |B|, |K| and their signs ----------------
   logic [AW-1:0] a3_ff;
   logic [BW-1:0] bm3_ff;
   logic [KW-1:0] km3_ff;
   logic          bneg3_ff, kneg3_ff, aok3_ff;
   logic          bneg_in3, kneg_in3;

   assign bneg_in3 = pos_ff < neg_ff;
   assign kneg_in3 = vv_ff < KW'(r2_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         a3_ff    <= a2_ff;
         bneg3_ff <= bneg_in3;
         bm3_ff   <= bneg_in3 ? neg_ff - pos_ff : pos_ff - neg_ff;
         kneg3_ff <= kneg_in3;
         km3_ff   <= kneg_in3 ? KW'(r2_ff) - vv_ff : vv_ff - KW'(r2_ff);
         aok3_ff  <= a2_ff != '0;     // zero direction never hits
      end
   end

   // ---------------- B*B and A*K ----------------
   logic [2*BW-1:0]  bb_p;
   logic [KW+BW-1:0] ak_p;
   logic [P2W-1:0]   pay_m2;
   logic [AW-1:0]    a_m2;
   logic [BW-1:0]    bm_m2;
   logic             bneg_m2, kneg_m2, aok_m2;

   rsi_mul #(.AW(BW), .BW(BW), .PW(P2W)) u_bb (
      .clock(clock), .en(adv), .a(bm3_ff), .b(bm3_ff),
      .pay_in({a3_ff, bm3_ff, bneg3_ff, kneg3_ff, aok3_ff}),
      .prod(bb_p), .pay_out(pay_m2)
   );

   rsi_mul #(.AW(KW), .BW(BW), .PW(1)) u_ak (
      .clock(clock), .en(adv), .a(km3_ff), .b(BW'(a3_ff)),
      .pay_in(1'b0), .prod(ak_p), .pay_out()
   );

   assign {a_m2, bm_m2, bneg_m2, kneg_m2, aok_m2} = pay_m2;

   // ---------------- stage 4: discriminant ----------------
   logic [DW-1:0] disc_ff;
   logic [AW-1:0] a4_ff;
   logic [BW-1:0] bm4_ff;
   logic          bneg4_ff, ok4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         disc_ff  <= kneg_m2 ? DW'(bb_p) + DW'(ak_p) : DW'(bb_p) - DW'(ak_p);
         ok4_ff   <= aok_m2 && (kneg_m2 || (DW'(bb_p) >= DW'(ak_p)));
         a4_ff    <= a_m2;
         bm4_ff   <= bm_m2;
         bneg4_ff <= bneg_m2;
      end
   end

   // ---------------- square root row ----------------
   logic [SW-1:0]  s_root;
   logic [PSW-1:0] pay_sq;
   logic [AW-1:0]  a_sq;
   logic [BW-1:0]  bm_sq;
   logic           bneg_sq, ok_sq;

   rsi_sqrt #(.DW(DW), .PW(PSW)) u_sqrt (
      .clock(clock), .en(adv), .rad(disc_ff),
      .pay_in({a4_ff, bm4_ff, bneg4_ff, ok4_ff}),
      .root(s_root), .pay_out(pay_sq)
   );

   assign {a_sq, bm_sq, bneg_sq, ok_sq} = pay_sq;

   // ---------------- stage 5: root numerators ----------------
   logic [NW-1:0] sx, bx;
   logic [NW-1:0] numn_ff, numf_ff;
   logic [AW-1:0] a5_ff;
   logic          nok_ff, fok_ff;

   assign sx = NW'(s_root);
   assign bx = NW'(bm_sq);

   always_ff @(posedge clock) begin
      if (adv) begin
         a5_ff   <= a_sq;
         // near root (-B - S)/A is positive only when -B exceeds S
         nok_ff  <= ok_sq && bneg_sq && (bx > sx);
         numn_ff <= bx - sx;
         fok_ff  <= ok_sq && (bneg_sq || (sx > bx));
         numf_ff <= bneg_sq ? bx + sx : sx - bx;
      end
   end

   // ---------------- divider rows, near and far in lockstep ----------------
   logic [DIST_W-1:0] qn, qf;
   logic              nok_d, fok_d;

   rsi_div #(.NW(NW), .AW(AW), .FB(FRAC_BITS), .PW(2)) u_div_near (
      .clock(clock), .en(adv), .num(numn_ff), .den(a5_ff),
      .pay_in({nok_ff, fok_ff}), .quo(qn), .pay_out({nok_d, fok_d})
   );

   rsi_div #(.NW(NW), .AW(AW), .FB(FRAC_BITS), .PW(1)) u_div_far (
      .clock(clock), .en(adv), .num(numf_ff), .den(a5_ff),
      .pay_in(1'b0), .quo(qf), .pay_out()
   );

   // ---------------- stage 6: pick the first root past epsilon ----------------
   logic              hit_n, hit_f;
   logic              hit_ff;
   logic [DIST_W-1:0] dist_ff;

   assign hit_n = nok_d && (qn >= DIST_W'(EPS));
   assign hit_f = fok_d && (qf >= DIST_W'(EPS));

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= hit_n || hit_f;
         dist_ff <= hit_n ? qn : (hit_f ? qf : '0);
      end
   end

   assign rsp_tdata = {dist_ff, hit_ff};

   // ---------------- checks ----------------
   `RSI_ASSERT_NOW(a_miss_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[RSP_W-1:1] == '0, "miss with nonzero distance")
   `RSI_ASSERT_NOW(a_hit_eps, rsp_tvalid && rsp_tdata[0], rsp_tdata[RSP_W-1:1] >= DIST_W'(EPS), "hit below epsilon")
   `RSI_ASSERT_NEXT(a_req_enters, req_tvalid && req_tready, vld_ff[0], "accepted ray lost at entry")

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// ray sphere intersect testbench: rays are streamed in against several sphere
// settings, every result is checked against an exact wide-integer hit predictor
// ----------------------------------------------------------------------------
module tb_top;
   import rsi_pkg::*;

   localparam int  EPS_LSB     = 7;            // ceil(1e-4 * 2^16)
   localparam int  DIST_MAX    = 32'h7fff_ffff;
   localparam int  WDOG_LIMIT  = 20000;        // cycles with no handshake at all
   localparam int  DRAIN_GAP   = 200;          // longer than the pipeline latency
   localparam int  HOLD_CYCLES = 1500;         // long receiver hold-off
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'd9;  // no register behind it

   typedef struct {
      logic signed [31:0] org [3];
      logic signed [31:0] dir [3];
   } ray_type;

   typedef struct {
      logic        hit;
      logic [30:0] distance;
   } hit_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // sphere shadow registers
   logic signed [31:0] sph_center [3];
   logic [30:0]        sph_radius;

   hit_type expected_hits [$];
   int   error_count = 0;
   int   idle_cycles;
   int   hold_left;
   bit   hold_req;       // asks the result side for its long hold-off
   bit   hold_seen;
   bit   quiet;          // no random idling on either side

   ray_sphere_intersect u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // integer square root, floor, 112 result bits
   function automatic logic [255:0] isqrt(logic [255:0] val);
      logic [255:0] root;
      logic [255:0] trial;
      root = '0;
      for (int k = 111; k >= 0; k--) begin
         trial = root | (256'd1 << k);
         if (trial * trial <= val) root = trial;
      end
      return root;
   endfunction

   // floor(num * 2^16 / a) limited to the distance range
   function automatic logic [30:0] scaled_dist(logic signed [255:0] num,
                                                logic signed [255:0] a);
      logic signed [255:0] quo;
      quo = (num <<< 16) / a;
      if (quo > DIST_MAX) quo = DIST_MAX;
      return quo[30:0];
   endfunction

   // exact quadratic: a = d.d, b = v.d (half), k = v.v - r^2, disc = b^2 - a*k
   function automatic hit_type predict_hit(ray_type r);
      logic signed [255:0] v, d, a, b, vv, rr, k, disc, s, n1, n2;
      logic [30:0]         q;
      hit_type             res;
      res.hit = 1'b0;
      res.distance = '0;
      a = 0;
      b = 0;
      vv = 0;
      for (int i = 0; i < 3; i++) begin
         v = r.org[i];
         v = v - sph_center[i];
         d = r.dir[i];
         a = a + d * d;
         b = b + v * d;
         vv = vv + v * v;
      end
      rr = sph_radius;
      k = vv - rr * rr;
      // zero direction never hits
      if (a == 0) return res;
      disc = b * b - a * k;
      // negative discriminant, the ray misses
      if (disc < 0) return res;
      s = isqrt(disc);
      // near root first, then far root, skipping those behind or below epsilon
      n1 = -b - s;
      if (n1 > 0) begin
         q = scaled_dist(n1, a);
         if (q >= EPS_LSB) begin
            res.hit = 1'b1;
            res.distance = q;
            return res;
         end
      end
      n2 = -b + s;
      if (n2 > 0) begin
         q = scaled_dist(n2, a);
         if (q >= EPS_LSB) begin
            res.hit = 1'b1;
            res.distance = q;
         end
      end
      return res;
   endfunction

   // result side: ready with random idling and the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_seen <= 1'b0;
      end else if (hold_req && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 9);
      end
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result request %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_tdata[0] !== want.hit) begin
               $display("%0t: hit mismatch expected %0d actual %0d",
                        $time, want.hit, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[31:1] !== want.distance) begin
               $display("%0t: hit_distance mismatch expected %h actual %h",
                        $time, want.distance, rsp_tdata[31:1]);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake anywhere
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_ray(ray_type r);
      // random gap before the request, none while quiet
      if (!quiet && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.dir[2], r.dir[1], r.dir[0], r.org[2], r.org[1], r.org[0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_hits.push_back(predict_hit(r));
   endtask

   task automatic stop_rays();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // all results in, then let the pipeline empty out
   task automatic drain();
      stop_rays();
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_CENTER_X: sph_center[0] = val;
         REG_CENTER_Y: sph_center[1] = val;
         REG_CENTER_Z: sph_center[2] = val;
         REG_RADIUS:   sph_radius = val[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] rad);
      drain();
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, rad);
   endtask

   function automatic ray_type make_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                        logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
      ray_type r;
      r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
      r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
      return r;
   endfunction

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         4: return 32'h0000_0001;
         default: return 32'h0001_0000;
      endcase
   endfunction

   // small signed value, about +-16.0
   function automatic logic [31:0] small_coord();
      return $urandom_range(32'h0020_0000) - 32'h0010_0000;
   endfunction

   // mostly rays aimed near the sphere, some noise and extremes
   function automatic ray_type random_ray();
      ray_type r;
      int   sel;
      logic [31:0] tgt;
      sel = $urandom_range(99);
      for (int i = 0; i < 3; i++) begin
         if (sel < 70) begin
            r.org[i] = sph_center[i] + small_coord();
            tgt = sph_center[i] + ($urandom_range(32'h0008_0000) - 32'h0004_0000);
            r.dir[i] = ($urandom_range(3) == 0) ? (tgt - r.org[i]) >>> $urandom_range(4)
                                                 : tgt - r.org[i];
         end else if (sel < 85) begin
            r.org[i] = small_coord();
            r.dir[i] = small_coord();
         end else if (sel < 95) begin
            r.org[i] = $urandom;
            r.dir[i] = $urandom;
         end else begin
            r.org[i] = pick_extreme();
            r.dir[i] = pick_extreme();
         end
      end
      return r;
   endfunction

   // directed rays: hits from outside and inside, misses, behind, zero
   // direction, grazing, saturated distance and full-scale fields
   task automatic test_directed_cases();
      set_sphere(32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 32'h0001_0000);
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h0001_0000));             // near root hit
      send_ray(make_ray(0, 0, 32'h0005_0000, 32'h0001_0000, 0, 0)); // from inside
      send_ray(make_ray(0, 0, 0, 0, 0, 32'hffff_0000));             // sphere behind
      send_ray(make_ray(0, 0, 0, 0, 0, 0));                         // zero direction
      send_ray(make_ray(0, 32'h0002_0000, 0, 0, 0, 32'h0001_0000)); // miss
      send_ray(make_ray(32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000)); // grazing
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h0000_0001));             // saturates
      send_ray(make_ray(0, 0, 32'h0004_0000, 0, 0, 32'h0001_0000)); // on surface
      send_ray(make_ray(0, 0, 32'h0004_0004, 0, 0, 32'h0001_0000)); // near root just behind
      send_ray(make_ray(0, 0, 32'h0005_fffc, 0, 0, 32'h0001_0000)); // far under eps
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h7fff_ffff));
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h8000_0000));
      send_ray(make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_ray(make_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_ray(make_ray('1, '1, '1, '1, '1, '1));
      // huge sphere with the corner centre, plus a write to a missing register
      set_sphere(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
      csr_write(REG_SPARE, 32'hdead_beef);
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h0001_0000));
      send_ray(make_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
      send_ray(make_ray(0, 0, 0, 32'h0000_0001, 0, 0));
      // zero radius point sphere
      set_sphere(0, 0, 32'h0003_0000, 0);
      send_ray(make_ray(0, 0, 0, 0, 0, 32'h0001_0000));
      send_ray(make_ray(0, 0, 0, 0, 32'h0000_0001, 32'h0001_0000));
      drain();
   endtask

   task automatic test_random_rays();
      logic [31:0] rad;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_sphere(small_coord(), small_coord(), small_coord(), 32'h0002_0000);
            1: set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
            2: set_sphere(small_coord(), small_coord(), small_coord(), 32'h0000_0001);
            3: set_sphere($urandom, $urandom, $urandom, $urandom);
            4: set_sphere(0, 0, 0, 0);
            default: begin
               rad = $urandom_range(32'h0008_0000);
               set_sphere(small_coord(), small_coord(), small_coord(), rad | 32'h8000_0000);
            end
         endcase
         // one stretch without idling on either side
         quiet = (phase == 2);
         repeat (250) send_ray(random_ray());
         quiet = 1'b0;
      end
      drain();
   endtask

   // receiver holds off while the sender keeps offering, filling the pipe
   task automatic test_result_stall();
      set_sphere(small_coord(), small_coord(), small_coord(), 32'h0004_0000);
      hold_req = 1'b1;
      quiet = 1'b1;
      repeat (300) send_ray(random_ray());
      quiet = 1'b0;
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_index = REG_CENTER_X;
      csr_data = '0;
      hold_req = 1'b0;
      quiet = 1'b0;
      sph_center[0] = 0;
      sph_center[1] = 0;
      sph_center[2] = 0;
      sph_radius = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_rays();
      test_result_stall();
      repeat (DRAIN_GAP) @(posedge clock);
      if (error_count == 0 && expected_hits.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
